>>> src/bcl_pkg.sv
// Shared types, constants and register codes for the debounced button code lock.
`timescale 1ns / 1ps
package bcl_pkg;

	// Per-button elapsed tick counter width
	localparam int TIMER_WIDTH = 16;
	localparam int NUM_BUTTONS = 4;
	localparam int DEBOUNCE_WIDTH = 16;
	localparam int CODE_WIDTH = 8;
	localparam int TRY_WIDTH = 14;
	localparam int CMP_WIDTH = (TIMER_WIDTH > DEBOUNCE_WIDTH) ? TIMER_WIDTH : DEBOUNCE_WIDTH;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [NUM_BUTTONS-1:0] button_mask_t;
	typedef logic [TRY_WIDTH-1:0] try_t;

	localparam timer_t TIMER_MAX = '1;
	localparam try_t TRY_MAX = '1;

	// Reset values of the configuration registers
	localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd100;
	localparam logic [CODE_WIDTH-1:0] CODE_RESET = 8'd184;
	localparam try_t TRY_CAP_RESET = 14'd9999;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEBOUNCE_MS = 2'd0,
		REG_CODE_WORD = 2'd1,
		REG_TRY_CAP = 2'd2
	} reg_index_t;

	localparam int LAST_STEP = 3;

	typedef enum logic [1:0] {
		VERDICT_NONE = 2'd0,
		VERDICT_ACCEPT = 2'd1,
		VERDICT_FAIL = 2'd2
	} verdict_t;

	// Matcher result handed to the output register
	typedef struct packed {
		verdict_t verdict;
		logic [1:0] progress;
		try_t tries_used;
	} match_result_t;

endpackage

>>> src/bcl_debounce.sv
// Per-button press detection with held flags and saturating elapsed counters.
`timescale 1ns / 1ps
module bcl_debounce
	import bcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic advance,
	input button_mask_t levels,
	input logic [DEBOUNCE_WIDTH-1:0] debounce_ms,
	output button_mask_t press
);

	button_mask_t held_q;
	button_mask_t held_d;
	timer_t elapsed_q [NUM_BUTTONS];
	timer_t elapsed_d [NUM_BUTTONS];
	timer_t elapsed_inc [NUM_BUTTONS];

	// Work out presses and next held state for each button
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			elapsed_inc[i] = (elapsed_q[i] == TIMER_MAX) ? elapsed_q[i]
				: timer_t'(elapsed_q[i] + 1'b1);
			press[i] = 1'b0;
			held_d[i] = held_q[i];
			elapsed_d[i] = elapsed_inc[i];
			if (levels[i] && !held_q[i]) begin
				press[i] = 1'b1;
				held_d[i] = 1'b1;
				elapsed_d[i] = '0;
			end else if (!levels[i] && held_q[i]) begin
				// release only once the debounce window has passed
				if (CMP_WIDTH'(elapsed_inc[i]) > CMP_WIDTH'(debounce_ms)) begin
					held_d[i] = 1'b0;
				end
			end
		end
	end

	// Hold state between items, advance on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				elapsed_q[i] <= '0;
			end
		end else if (advance) begin
			held_q <= held_d;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				elapsed_q[i] <= elapsed_d[i];
			end
		end
	end

endmodule

>>> src/bcl_matcher.sv
// Code step matcher and try counter of the code lock.
`timescale 1ns / 1ps
module bcl_matcher
	import bcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic advance,
	input button_mask_t press,
	input logic [CODE_WIDTH-1:0] code_word,
	input try_t try_cap,
	output match_result_t result
);

	logic [1:0] step_q;
	try_t tries_q;
	logic [1:0] want;
	logic [1:0] step_d;
	try_t tries_d;
	try_t tries_inc;
	verdict_t verdict_d;

	// Select the button expected at the current step
	always_comb begin
		case (step_q)
			2'd0: want = code_word[1:0];
			2'd1: want = code_word[3:2];
			2'd2: want = code_word[5:4];
			2'd3: want = code_word[7:6];
			default: want = code_word[1:0];
		endcase
	end

	assign tries_inc = (tries_q == TRY_MAX) ? tries_q : try_t'(tries_q + 1'b1);

	// Advance or drop the match, then check the try limit
	always_comb begin
		step_d = step_q;
		tries_d = tries_q;
		verdict_d = VERDICT_NONE;
		if (press != '0) begin
			if (press[want]) begin
				if (step_q == 2'(LAST_STEP)) begin
					verdict_d = VERDICT_ACCEPT;
					step_d = '0;
					tries_d = '0;
				end else begin
					step_d = 2'(step_q + 1'b1);
					tries_d = tries_inc;
				end
			end else begin
				step_d = '0;
				tries_d = tries_inc;
			end
		end
		if (verdict_d == VERDICT_NONE && tries_d >= try_cap) begin
			verdict_d = VERDICT_FAIL;
			step_d = '0;
			tries_d = '0;
		end
	end

	assign result.verdict = verdict_d;
	assign result.progress = step_d;
	assign result.tries_used = tries_d;

	// Hold matcher state between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			tries_q <= '0;
		end else if (advance) begin
			step_q <= step_d;
			tries_q <= tries_d;
		end
	end

endmodule

>>> src/debounced_button_code_lock.sv
// Top level of the debounced four-button code lock.
//
// Usage: one item per millisecond tick on the input channel (in_valid/in_ready)
// carries the raw levels of four buttons. For every item exactly one result
// leaves on the output channel (out_valid/out_ready): the new-press mask, the
// verdict (none, accepted, failed), the code steps matched and the tries used.
// Configuration (debounce_ms, code_word, try_cap) is written through the
// cfg channel by register index, index 3 ignored; the user must write it only
// while no item is in flight, which the block does not enforce. An accepted
// item is registered, processed against the debounce and matcher state, and
// its result registered in the result register. Throughput is one item per
// cycle while the output is not stalled; a new item is taken while an earlier
// result still waits on the output register. When the receiver stalls, the
// result holds and the input register fills, after which in_ready drops until
// the output moves. Reset clears held flags, elapsed counters, code step and
// try count, and returns the configuration registers to 100, 184 and 9999.
`timescale 1ns / 1ps
module debounced_button_code_lock
	import bcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] button_levels,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] press_mask,
	output logic [1:0] verdict,
	output logic [1:0] progress,
	output logic [13:0] tries_used,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic [DEBOUNCE_WIDTH-1:0] debounce_q;
	logic [CODE_WIDTH-1:0] code_q;
	try_t try_cap_q;

	logic valid_s1;
	button_mask_t levels_s1;
	logic advance;
	button_mask_t press;
	match_result_t result;

	logic out_valid_q;
	button_mask_t press_q;
	match_result_t result_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			code_q <= CODE_RESET;
			try_cap_q <= TRY_CAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_MS: debounce_q <= cfg_data;
				REG_CODE_WORD: code_q <= cfg_data[CODE_WIDTH-1:0];
				REG_TRY_CAP: try_cap_q <= cfg_data[TRY_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Process the registered item when the output register can take its result
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			levels_s1 <= button_levels;
		end
	end

	bcl_debounce u_debounce (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.levels(levels_s1),
		.debounce_ms(debounce_q),
		.press(press)
	);

	bcl_matcher u_matcher (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.press(press),
		.code_word(code_q),
		.try_cap(try_cap_q),
		.result(result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			press_q <= press;
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign press_mask = press_q;
	assign verdict = result_q.verdict;
	assign progress = result_q.progress;
	assign tries_used = result_q.tries_used;

`ifndef NO_ASSERTIONS
	// A finished attempt leaves the matcher cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.verdict != VERDICT_NONE
		|-> result_q.progress == 2'd0 && result_q.tries_used == '0)
		else $error("verdict reported without clearing progress and tries");

	// A press is only reported for a button that reads high
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (press & ~levels_s1) == '0)
		else $error("press reported for a low button");

	// Input stalls only when both registers are full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");
`endif

endmodule
